// ===== src/hrdp_pkg.sv =====
// Package for the HID report descriptor parser.
// Holds sizes, state and record codes, and the controller/datapath structs.
`timescale 1ns / 1ps
package hrdp_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int MAX_NEST    = 15;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_AW      = $clog2(STACK_DEPTH) + 4;
  localparam int DEPTH_W     = $clog2(MAX_NEST + 1);

  localparam logic [1:0] KIND_MAIN   = 2'd0;
  localparam logic [1:0] KIND_GLOBAL = 2'd1;
  localparam logic [1:0] KIND_LOCAL  = 2'd2;

  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [3:0] TAG_PUSH     = 4'hA;
  localparam logic [3:0] TAG_POP      = 4'hB;
  localparam logic [3:0] TAG_COLL     = 4'hA;
  localparam logic [3:0] TAG_END_COLL = 4'hC;
  localparam logic [3:0] TAG_LONG     = 4'hF;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_DATA,
    PH_LSIZE,
    PH_LTAG
  } parse_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAIN,
    ST_SWEEP,
    ST_PUSH,
    ST_POP,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic       accept;
    logic       exec_main;
    logic       wr_global;
    logic       wr_local;
    logic       pop_empty;
    logic       set_err;
    logic       push_wr;
    logic       pop_rd;
    logic       sp_inc;
    logic       sp_dec;
    logic       load_main;
    logic       load_entry;
    logic       clr_local;
    logic       soft_reset;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       done_now;
    logic [1:0] item_type;
    logic [3:0] item_tag;
    logic       sp_full;
    logic       sp_empty;
    logic       out_free;
    logic       cur_valid;
  } status_t;

  function automatic logic [2:0] short_size(input logic [1:0] code);
    return (code == 2'd3) ? 3'd4 : {1'b0, code};
  endfunction

endpackage

// ===== src/hrdp_dp.sv =====
// Datapath of the HID report descriptor parser: byte parser, global and local
// tables, push stack memory, nesting depth and the output register. Uses hrdp_pkg.
`timescale 1ns / 1ps
module hrdp_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrdp_pkg::cmd_t  cmd_i,
  output hrdp_pkg::status_t sts_o,
  input  logic [7:0]      byte_i,
  input  logic            m_ready_i,
  output logic            m_valid_o,
  output logic [1:0]      m_kind_o,
  output logic [3:0]      m_tag_o,
  output logic [31:0]     m_data_o,
  output logic [2:0]      m_size_o,
  output logic [3:0]      m_depth_o,
  output logic            m_err_o,
  output logic            m_last_o
);
  import hrdp_pkg::*;

  parse_phase_e phase_q, phase_d;
  logic [7:0]   left_q, left_d;
  logic [7:0]   prefix_q, prefix_d;
  logic [31:0]  accum_q, accum_d;
  logic         done_now;

  logic [31:0]  gdata_q [16];
  logic [2:0]   gsize_q [16];
  logic [15:0]  gval_q;
  logic [31:0]  ldata_q [16];
  logic [2:0]   lsize_q [16];
  logic [15:0]  lval_q;

  logic [35:0]  stack_mem [STACK_DEPTH * 16];
  logic [35:0]  rd_q;
  logic [3:0]   pidx_q;
  logic         pwr_q;
  logic [SP_W-1:0] sp_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [DEPTH_W-1:0] depth_rec_q;
  logic         err_q;

  logic [MEM_AW-1:0] mem_addr;
  logic [31:0]  vall;
  logic [31:0]  vabove;
  logic         is_long;
  logic [1:0]   bidx;
  logic [2:0]   psize;
  logic [3:0]   eidx;

  assign is_long  = (prefix_q[7:4] == TAG_LONG);
  assign psize    = short_size(prefix_q[1:0]);
  assign bidx     = 2'(psize - left_q[2:0]);
  assign vall     = {lval_q, gval_q};
  assign vabove   = vall >> cmd_i.idx;
  assign eidx     = cmd_i.idx[3:0];
  assign mem_addr = MEM_AW'({sp_q, eidx});

  // Byte parser: next phase for the accepted byte.
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    prefix_d = prefix_q;
    accum_d  = accum_q;
    done_now = 1'b0;
    unique case (phase_q)
      PH_PREFIX: begin
        prefix_d = byte_i;
        accum_d  = '0;
        if (byte_i[7:4] == TAG_LONG) begin
          phase_d = PH_LSIZE;
        end else begin
          left_d = {5'd0, short_size(byte_i[1:0])};
          if (byte_i[1:0] == 2'd0) begin
            done_now = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (!is_long) begin
          accum_d = accum_q | (32'(byte_i) << {bidx, 3'b000});
        end
        if (left_q != 8'd0) begin
          left_d = left_q - 8'd1;
        end
        if (left_d == 8'd0) begin
          phase_d  = PH_PREFIX;
          done_now = !is_long;
        end
      end
      PH_LSIZE: begin
        left_d  = byte_i;
        phase_d = PH_LTAG;
      end
      PH_LTAG: begin
        phase_d = (left_q != 8'd0) ? PH_DATA : PH_PREFIX;
      end
      default: phase_d = PH_PREFIX;
    endcase
  end

  assign sts_o.done_now  = done_now;
  assign sts_o.item_type = prefix_q[3:2];
  assign sts_o.item_tag  = prefix_q[7:4];
  assign sts_o.sp_full   = (sp_q >= SP_W'(STACK_DEPTH));
  assign sts_o.sp_empty  = (sp_q == '0);
  assign sts_o.out_free  = !m_valid_o || m_ready_i;
  assign sts_o.cur_valid = vabove[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      left_q   <= '0;
      prefix_q <= '0;
      accum_q  <= '0;
      gval_q   <= '0;
      lval_q   <= '0;
      sp_q     <= '0;
      depth_q  <= '0;
      err_q    <= 1'b0;
      pwr_q    <= 1'b0;
      m_valid_o <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        phase_q  <= phase_d;
        left_q   <= left_d;
        prefix_q <= prefix_d;
        accum_q  <= accum_d;
      end
      if (cmd_i.exec_main) begin
        if (prefix_q[7:4] == TAG_COLL) begin
          if (depth_q >= DEPTH_W'(MAX_NEST)) begin
            depth_q <= DEPTH_W'(MAX_NEST);
            err_q   <= 1'b1;
          end else begin
            depth_q <= depth_q + 1'b1;
          end
        end else if (prefix_q[7:4] == TAG_END_COLL) begin
          if (depth_q == '0) begin
            err_q <= 1'b1;
          end else begin
            depth_q <= depth_q - 1'b1;
          end
        end
      end
      if (cmd_i.wr_global) gval_q[prefix_q[7:4]] <= 1'b1;
      if (cmd_i.wr_local)  lval_q[prefix_q[7:4]] <= 1'b1;
      if (cmd_i.set_err)   err_q <= 1'b1;
      if (cmd_i.pop_empty) begin
        gval_q <= '0;
        err_q  <= 1'b1;
      end
      if (cmd_i.sp_inc) sp_q <= sp_q + 1'b1;
      if (cmd_i.sp_dec) sp_q <= sp_q - 1'b1;
      pwr_q <= cmd_i.pop_rd;
      if (pwr_q && !cmd_i.soft_reset) gval_q[pidx_q] <= rd_q[35];
      if (cmd_i.clr_local) lval_q <= '0;

      if (cmd_i.load_main || cmd_i.load_entry) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end

      // End of descriptor: parse state, table valid bits, stack pointer, depth and error back to reset values.
      if (cmd_i.soft_reset) begin
        phase_q  <= PH_PREFIX;
        left_q   <= '0;
        prefix_q <= '0;
        accum_q  <= '0;
        gval_q   <= '0;
        lval_q   <= '0;
        sp_q     <= '0;
        depth_q  <= '0;
        err_q    <= 1'b0;
      end
    end
  end

  // Payload registers: tables, stack memory and output record.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_main) depth_rec_q <= depth_q;
    if (cmd_i.wr_global) begin
      gdata_q[prefix_q[7:4]] <= accum_q;
      gsize_q[prefix_q[7:4]] <= psize;
    end
    if (cmd_i.wr_local) begin
      ldata_q[prefix_q[7:4]] <= accum_q;
      lsize_q[prefix_q[7:4]] <= psize;
    end
    if (cmd_i.push_wr) begin
      stack_mem[mem_addr] <= {gval_q[eidx], gsize_q[eidx], gdata_q[eidx]};
    end
    if (cmd_i.pop_rd) begin
      rd_q   <= stack_mem[mem_addr];
      pidx_q <= eidx;
    end
    if (pwr_q) begin
      gdata_q[pidx_q] <= rd_q[31:0];
      gsize_q[pidx_q] <= rd_q[34:32];
    end
    if (cmd_i.load_main) begin
      m_kind_o  <= KIND_MAIN;
      m_tag_o   <= prefix_q[7:4];
      m_data_o  <= accum_q;
      m_size_o  <= psize;
      m_depth_o <= 4'(depth_rec_q);
      m_err_o   <= err_q;
      m_last_o  <= (vall == '0);
    end else if (cmd_i.load_entry) begin
      m_kind_o  <= cmd_i.idx[4] ? KIND_LOCAL : KIND_GLOBAL;
      m_tag_o   <= eidx;
      m_data_o  <= cmd_i.idx[4] ? ldata_q[eidx] : gdata_q[eidx];
      m_size_o  <= cmd_i.idx[4] ? lsize_q[eidx] : gsize_q[eidx];
      m_depth_o <= 4'(depth_rec_q);
      m_err_o   <= err_q;
      m_last_o  <= (vabove[31:1] == '0);
    end
  end

endmodule

// ===== src/hrdp_ctrl.sv =====
// Controller of the HID report descriptor parser: sequences item execution,
// record emission, stack push and pop sweeps. Uses hrdp_pkg.
`timescale 1ns / 1ps
module hrdp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_last_i,
  input  hrdp_pkg::status_t sts_i,
  output hrdp_pkg::cmd_t    cmd_o
);
  import hrdp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  idx_q, idx_d;
  logic        eod_q, eod_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      eod_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      eod_q   <= eod_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    eod_d      = eod_q;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          eod_d        = in_last_i;
          state_d      = sts_i.done_now ? ST_EXEC : ST_FIN;
        end
      end
      ST_EXEC: begin
        idx_d   = '0;
        state_d = ST_FIN;
        unique case (sts_i.item_type)
          TYPE_MAIN: begin
            cmd_o.exec_main = 1'b1;
            state_d         = ST_MAIN;
          end
          TYPE_GLOBAL: begin
            if (sts_i.item_tag == TAG_PUSH) begin
              if (sts_i.sp_full) cmd_o.set_err = 1'b1;
              else state_d = ST_PUSH;
            end else if (sts_i.item_tag == TAG_POP) begin
              if (sts_i.sp_empty) begin
                cmd_o.pop_empty = 1'b1;
              end else begin
                cmd_o.sp_dec = 1'b1;
                state_d      = ST_POP;
              end
            end else begin
              cmd_o.wr_global = 1'b1;
            end
          end
          TYPE_LOCAL: cmd_o.wr_local = 1'b1;
          default: ;
        endcase
      end
      ST_MAIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_main = 1'b1;
          state_d         = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // One table slot per cycle; valid slots wait for room at the output.
        if (!sts_i.cur_valid || sts_i.out_free) begin
          cmd_o.load_entry = sts_i.cur_valid;
          idx_d            = idx_q + 5'd1;
          if (idx_q == 5'd31) begin
            cmd_o.clr_local = 1'b1;
            state_d         = ST_FIN;
          end
        end
      end
      ST_PUSH: begin
        cmd_o.push_wr = 1'b1;
        idx_d         = idx_q + 5'd1;
        if (idx_q[3:0] == 4'hF) begin
          cmd_o.sp_inc = 1'b1;
          state_d      = ST_FIN;
        end
      end
      ST_POP: begin
        cmd_o.pop_rd = 1'b1;
        idx_d        = idx_q + 5'd1;
        if (idx_q[3:0] == 4'hF) state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.soft_reset = eod_q;
        eod_d            = 1'b0;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/hid_report_descriptor_parser_top.sv =====
// Top level of the HID report descriptor parser.
// Instantiates hrdp_ctrl and hrdp_dp; uses hrdp_pkg.
`timescale 1ns / 1ps
// The parser takes one descriptor byte at a time and returns a run of records for
// every main item: the main record, then each valid global entry, then each
// valid local entry, with tlast on the final record. A byte that completes an
// item is executed, and each byte passes a finish state before the next is taken.
// A main item scans all 32 slots of both tables, waiting for room at the output
// on each valid one. Push and Pop copy the global table to or from the stack
// memory one entry per cycle; a Push on a full stack sets the error flag, and a
// Pop on an empty one also clears the global table. A byte with tlast set ends
// the descriptor and all parse state returns to its reset value.
module hid_report_descriptor_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // desc_byte
  input  logic        s_axis_tlast_i,   // end_of_descriptor
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // item_tag[3:0], item_data[35:4], item_size[38:36], nest_depth[42:39],
  // error_flag[43], zero fill[47:44]
  output logic [47:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // rec_kind
  output logic        m_axis_tlast_o    // last_of_run
);
  import hrdp_pkg::*;

  cmd_t        cmd;
  status_t     sts;
  logic [3:0]  tag;
  logic [31:0] data;
  logic [2:0]  size;
  logic [3:0]  depth;
  logic        err;

  hrdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_last_i  (s_axis_tlast_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hrdp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .byte_i    (s_axis_tdata_i),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_kind_o  (m_axis_tuser_o),
    .m_tag_o   (tag),
    .m_data_o  (data),
    .m_size_o  (size),
    .m_depth_o (depth),
    .m_err_o   (err),
    .m_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, err, depth, size, data, tag};

endmodule

// ===== src/hrdp_checker.sv =====
// Port-level checker for the HID report descriptor parser, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module hrdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled record keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output record changed while stalled");

  // The parser is not ready in the cycle after it accepts a byte.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  // Padding bits of tdata stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[47:44] == 4'd0)
    else $error("tdata fill bits not zero");

  // A table entry record always belongs to a run whose main record came first,
  // so the parser cannot be idle on the cycle after a main record is loaded.
  a_main_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) && m_axis_tuser_o == 2'd0 && !m_axis_tlast_o
      |-> !s_axis_tready_o)
    else $error("parser idle while a run is pending");

endmodule

bind hid_report_descriptor_parser_top hrdp_checker u_hrdp_checker (.*);

// ===== dv/hid_report_descriptor_parser_checker.sv =====
// Checker for the HID report descriptor parser: watches both streams,
// predicts the record runs and compares them. Depends on hrdp_pkg.
`timescale 1ns / 1ps
module hid_report_descriptor_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);
  import hrdp_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [2:0]  size;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [47:0] data;
  } record_t;

  record_t     record_q[$];
  parse_phase_e phase;
  logic [7:0]  left, prefix;
  logic [31:0] accum;
  entry_t      gtab [16];
  entry_t      ltab [16];
  entry_t      gstack [STACK_DEPTH][16];
  int          sp, depth;
  logic        err;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = record_q.size();

  function automatic logic [2:0] byte_count(input logic [7:0] p);
    return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
  endfunction

  task automatic clear_parse();
    phase = PH_PREFIX; left = 0; prefix = 0; accum = 0; sp = 0; depth = 0; err = 0;
    for (int i = 0; i < 16; i++) begin
      gtab[i] = '0; ltab[i] = '0;
    end
  endtask

  task automatic append_record(input record_t r);
    record_q.insert(record_q.size(), r);
  endtask

  task automatic push_record(input logic [1:0] kind, input logic [3:0] tag,
                             input logic [31:0] d, input logic [2:0] sz,
                             input logic [3:0] dep);
    record_t r;
    r.kind = kind; r.last = 0;
    r.data = {4'b0, err, dep, sz, d, tag};
    append_record(r);
  endtask

  task automatic finish_item();
    logic [1:0] ty;
    logic [3:0] tg, dep;
    logic [2:0] sz;
    record_t r;
    ty = prefix[3:2]; tg = prefix[7:4]; sz = byte_count(prefix);
    if (ty == TYPE_MAIN) begin
      dep = depth[3:0];
      if (tg == TAG_COLL) begin
        if (depth >= MAX_NEST) err = 1; else depth++;
      end else if (tg == TAG_END_COLL) begin
        if (depth == 0) err = 1; else depth--;
      end
      push_record(KIND_MAIN, tg, accum, sz, dep);
      for (int i = 0; i < 16; i++)
        if (gtab[i].valid) push_record(KIND_GLOBAL, 4'(i), gtab[i].data, gtab[i].size, dep);
      for (int i = 0; i < 16; i++)
        if (ltab[i].valid) push_record(KIND_LOCAL, 4'(i), ltab[i].data, ltab[i].size, dep);
      r = record_q.pop_back(); r.last = 1; append_record(r);
      for (int i = 0; i < 16; i++) ltab[i] = '0;
    end else if (ty == TYPE_GLOBAL) begin
      if (tg == TAG_PUSH) begin
        if (sp >= STACK_DEPTH) err = 1;
        else begin
          gstack[sp] = gtab; sp++;
        end
      end else if (tg == TAG_POP) begin
        if (sp == 0) begin
          for (int i = 0; i < 16; i++) gtab[i] = '0;
          err = 1;
        end else begin
          sp--; gtab = gstack[sp];
        end
      end else gtab[tg] = '{1'b1, sz, accum};
    end else if (ty == TYPE_LOCAL) begin
      ltab[tg] = '{1'b1, sz, accum};
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic eod);
    logic is_long;
    logic [1:0] idx;
    is_long = prefix[7:4] == TAG_LONG;
    case (phase)
      PH_PREFIX: begin
        prefix = b; accum = 0;
        if (b[7:4] == TAG_LONG) phase = PH_LSIZE;
        else begin
          left = 8'(byte_count(b));
          if (left == 0) finish_item(); else phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!is_long) begin
          idx = 2'(byte_count(prefix) - left[2:0]);
          accum = accum | (32'(b) << (8 * idx));
        end
        if (left > 0) left--;
        if (left == 0) begin
          phase = PH_PREFIX;
          if (!is_long) finish_item();
        end
      end
      PH_LSIZE: begin
        left = b; phase = PH_LTAG;
      end
      default: phase = (left != 0) ? PH_DATA : PH_PREFIX;
    endcase
    if (eod) clear_parse();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    record_t want;
    if (!rst_ni) begin
      clear_parse();
      record_q.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (record_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected record kind=%0d data=%h",
                                    m_axis_tuser_i, m_axis_tdata_i);
        end else begin
          want = record_q.pop_front();
          if (want.kind !== m_axis_tuser_i || want.data !== m_axis_tdata_i ||
              want.last !== m_axis_tlast_i) begin
            fails++;
            if (fails <= 10)
              $display("record mismatch: exp kind=%0d data=%h last=%b, got kind=%0d data=%h last=%b",
                       want.kind, want.data, want.last,
                       m_axis_tuser_i, m_axis_tdata_i, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
  end
endmodule

// ===== dv/hid_report_descriptor_parser_top_test.sv =====
// Testbench top for the HID report descriptor parser: drives descriptor
// bytes and output stalls. Uses hrdp_pkg and the checker module.
`timescale 1ns / 1ps
module hid_report_descriptor_parser_top_test;
  import hrdp_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0, s_tready, s_tlast = 0;
  logic [7:0]  s_tdata = 0;
  logic        m_tvalid, m_tready = 0, m_tlast;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fails, pending;
  int          cycles = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_off = 0;
  logic        stall_on = 1;
  logic [8:0]  byte_q[$];

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  hid_report_descriptor_parser_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast)
  );

  hid_report_descriptor_parser_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser), .m_axis_tlast_i(m_tlast),
    .fail_count_o(fails), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off requested by the stimulus.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= 300;
      m_tready <= 0;
    end else if (hold_off > 0) begin
      m_tready <= 0;
      hold_off <= hold_off - 1;
    end else if (!stall_on) m_tready <= 1;
    else m_tready <= (gap_len() == 0);
  end

  task automatic put_byte(input logic [8:0] v);
    byte_q.insert(byte_q.size(), v);
  endtask

  // Queue one short item: prefix plus its random data bytes.
  task automatic add_item(input logic [3:0] tag, input logic [1:0] ty, input logic [1:0] sz,
                          input logic eod);
    int n;
    n = (sz == 3) ? 4 : sz;
    put_byte({(eod && n == 0), tag, ty, sz});
    for (int i = 0; i < n; i++)
      put_byte({(eod && i == n - 1), 8'($urandom)});
  endtask

  task automatic add_long(input int len);
    put_byte({1'b0, TAG_LONG, 4'($urandom)});
    put_byte({1'b0, 8'(len)});
    put_byte({1'b0, 8'($urandom)});
    for (int i = 0; i < len; i++) put_byte({1'b0, 8'($urandom)});
  endtask

  task automatic send_all();
    logic [8:0] b;
    int g;
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      g = gap_len();
      if (g > 0) begin
        s_tvalid <= 0;
        repeat (g) @(posedge clk_i);
      end
      s_tvalid <= 1; s_tdata <= b[7:0]; s_tlast <= b[8];
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
    end
    s_tvalid <= 0; s_tlast <= 0;
  endtask

  task automatic drain();
    while (pending > 0) @(posedge clk_i);
  endtask

  initial begin
    int count, pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: all sizes, extremes, push/pop misuse, depth saturation, long items.
    add_item(4'h0, TYPE_GLOBAL, 2'd3, 0);
    put_byte({1'b0, 8'hFF});
    add_item(4'h9, TYPE_LOCAL, 2'd1, 0);
    add_item(4'h8, TYPE_MAIN, 2'd2, 0);
    add_item(TAG_POP, TYPE_GLOBAL, 2'd0, 0);
    add_item(TAG_END_COLL, TYPE_MAIN, 2'd0, 0);
    add_item(4'h3, 2'd3, 2'd1, 0);
    add_long(0);
    add_long(3);
    for (int i = 0; i < 5; i++) add_item(TAG_PUSH, TYPE_GLOBAL, 2'd0, 0);
    add_item(4'h1, TYPE_GLOBAL, 2'd2, 0);
    add_item(TAG_POP, TYPE_GLOBAL, 2'd0, 0);
    for (int i = 0; i < 17; i++) add_item(TAG_COLL, TYPE_MAIN, 2'd1, 0);
    add_item(4'hF - 1, TYPE_MAIN, 2'd3, 0);
    add_item(4'h2, TYPE_GLOBAL, 2'd3, 1);
    send_all();
    drain();

    // Long receiver hold-off while the sender keeps offering main items.
    hold_req++;
    for (int i = 0; i < 16; i++) add_item(4'($urandom), TYPE_GLOBAL, 2'($urandom), 0);
    for (int i = 0; i < 4; i++) add_item(4'h8, TYPE_MAIN, 2'd1, 0);
    send_all();
    drain();

    // Random: mostly well-formed items, some long items, end marks and noise bytes.
    count = 0;
    while (count < 300) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) add_long($urandom_range(0, 5));
      else if (pick < 6) put_byte({1'b0, 8'($urandom)});
      else if (pick < 8) put_byte({1'b1, 8'($urandom)});
      else if (pick < 30) add_item(pick[0] ? TAG_COLL : (pick[1] ? TAG_END_COLL : 4'($urandom)),
                                   TYPE_MAIN, 2'($urandom), 0);
      else if (pick < 40) add_item(pick[0] ? TAG_PUSH : TAG_POP, TYPE_GLOBAL, 2'($urandom), 0);
      else if (pick < 70) add_item(4'($urandom_range(0, 14)), TYPE_GLOBAL, 2'($urandom),
                                   $urandom_range(0, 40) == 0);
      else if (pick < 95) add_item(4'($urandom_range(0, 14)), TYPE_LOCAL, 2'($urandom), 0);
      else add_item(4'($urandom_range(0, 14)), 2'd3, 2'($urandom), 0);
      count += byte_q.size();
      if ($urandom_range(0, 9) == 0) stall_on = !stall_on;
      send_all();
      if ($urandom_range(0, 30) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
